>>> hdl/ils_pkg.sv
package ils_pkg;

    localparam int Order = 3;
    localparam int Cols  = Order + 1;
    localparam int NCoef = Order * Cols;
    localparam int AddrW = $clog2(NCoef);
    localparam int IdxW  = $clog2(Order);

    localparam logic [1:0] StConverged = 2'd0;
    localparam logic [1:0] StNotDom    = 2'd1;
    localparam logic [1:0] StLimit     = 2'd2;

    localparam logic       OpLoad  = 1'b0;
    localparam logic       OpSolve = 1'b1;

    localparam logic [1:0] RegMethod    = 2'd0;
    localparam logic [1:0] RegTolerance = 2'd1;
    localparam logic [1:0] RegMaxSweeps = 2'd2;

    typedef struct packed {
        logic               start;
        logic signed [95:0] num;
        logic signed [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } t_div_rsp;

endpackage

>>> hdl/ils_div.sv
module ils_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ils_pkg::t_div_req i_req,
    output ils_pkg::t_div_rsp o_rsp
);
    import ils_pkg::*;

    logic [95:0] r_rem;
    logic [95:0] r_quo;
    logic [31:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [96:0] w_trial;
    logic [95:0] w_qmag;
    logic        w_big;

    always_comb begin
        w_trial = {r_rem[95:0], r_quo[95]} - {65'd0, r_den};
    end

    always_comb begin
        w_qmag = r_quo;
        w_big  = r_neg ? (w_qmag > 96'h8000_0000) : (w_qmag > 96'h7FFF_FFFF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            o_rsp.done <= 1'b0;
            r_cnt      <= '0;
        end else begin
            o_rsp.done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd96;
                r_rem  <= '0;
                r_quo  <= i_req.num[95] ? 96'(-i_req.num) : i_req.num;
                r_den  <= i_req.den[31] ? 32'(-i_req.den) : i_req.den;
                r_neg  <= i_req.num[95] ^ i_req.den[31];
            end else if (r_busy && r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
                if (!w_trial[96]) begin
                    r_rem <= w_trial[95:0];
                    r_quo <= {r_quo[94:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[94:0], r_quo[95]};
                    r_quo <= {r_quo[94:0], 1'b0};
                end
            end else if (r_busy) begin
                r_busy     <= 1'b0;
                o_rsp.done <= 1'b1;
                if (w_big) begin
                    o_rsp.quo <= r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    o_rsp.quo <= r_neg ? 32'(-w_qmag) : w_qmag[31:0];
                end
            end
        end
    end

endmodule

>>> hdl/iterative_linear_solver_3x3.sv
// Coefficient loads leave no result. A solve holds busy high from the cycle
// after start until its single result strobe: a dominance check, which ends
// the solve if the matrix is not diagonally dominant, then for each sweep
// Order row updates (coefficient memory reads and products, then a restoring
// divider of the 96-bit numerator) and a convergence check of each unknown,
// and a final state to present the result. The result is shown for one cycle
// only and the receiver cannot stall it.
module iterative_linear_solver_3x3 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [1:0]  i_row,
    input  logic [1:0]  i_col,
    input  logic signed [31:0] i_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic signed [31:0] o_x_first,
    output logic signed [31:0] o_x_second,
    output logic signed [31:0] o_x_third,
    output logic [15:0] o_sweeps
);
    import ils_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DOM, S_ROW, S_MAC, S_DIV, S_CHECK, S_DONE
    } t_state;

    t_state r_state;
    logic signed [31:0] r_mem [NCoef];
    logic signed [31:0] r_rd;
    logic [AddrW-1:0]   w_raddr;
    logic               r_method;
    logic [15:0]        r_tol;
    logic [15:0]        r_max;
    logic signed [31:0] r_x  [Order];
    logic signed [31:0] r_px [Order];
    logic [15:0]        r_cnt;
    logic [IdxW-1:0]    r_i;
    logic [2:0]         r_j;
    logic               r_rdv;
    logic [2:0]         r_jd;
    logic [34:0]        r_off;
    logic [31:0]        r_diag;
    logic signed [95:0] r_num;
    logic signed [31:0] r_den;
    logic               r_ok;
    logic signed [63:0] r_prod;
    logic               r_pv;
    logic [2:0]         r_pj;
    t_div_req           w_req;
    t_div_rsp           w_rsp;
    logic [31:0]        w_abs;
    logic signed [31:0] w_xj;
    logic signed [32:0] w_dx;
    logic [32:0]        w_adx;
    logic               w_last;
    logic signed [63:0] w_tr;

    ils_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_raddr     = (r_j < 3'(Cols)) ? AddrW'(r_i * Cols + r_j) : '0;
    assign w_abs       = r_rd[31] ? 32'(-r_rd) : r_rd;
    assign w_xj        = r_method ? r_x[r_jd[IdxW-1:0]] : r_px[r_jd[IdxW-1:0]];
    assign w_tr        = r_prod[63] ? -((-r_prod) >>> 16) : (r_prod >>> 16);
    assign w_last      = (r_i == IdxW'(Order - 1));

    always_comb begin
        w_req.start = (r_state == S_ROW) && r_j == 3'(Cols + 1);
        w_req.num   = r_num <<< 16;
        w_req.den   = r_den;
    end

    always_comb begin
        w_dx  = 33'(r_x[r_i]) - 33'(r_px[r_i]);
        w_adx = w_dx[32] ? 33'(-w_dx) : w_dx;
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy && i_op == OpLoad && i_row < 2'(Order) && i_col <= 2'(Order)) begin
            r_mem[AddrW'(i_row * Cols + i_col)] <= i_value;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_method <= 1'b0;
            r_tol    <= 16'd1;
            r_max    <= 16'd1000;
            o_valid  <= 1'b0;
            r_rdv    <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    RegMethod:    r_method <= i_cfg_data[0];
                    RegTolerance: r_tol    <= i_cfg_data;
                    RegMaxSweeps: r_max    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_rdv <= 1'b0;
            r_pv  <= r_rdv && r_state == S_ROW && r_jd < 3'(Order);
            r_pj  <= r_jd;
            r_prod <= r_rd * w_xj;
            unique case (r_state)
                S_IDLE: begin
                    if (start && i_op == OpSolve) begin
                        for (int k = 0; k < Order; k++) begin
                            r_x[k]  <= '0;
                            r_px[k] <= '0;
                        end
                        r_cnt   <= '0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_off   <= '0;
                        r_ok    <= 1'b1;
                        r_state <= S_DOM;
                    end
                end
                S_DOM: begin
                    if (r_j < 3'(Order)) begin
                        r_jd    <= r_j;
                        r_rdv   <= 1'b1;
                        r_j     <= r_j + 3'd1;
                    end
                    if (r_rdv) begin
                        if (r_jd == 3'(r_i)) r_diag <= w_abs;
                        else r_off <= r_off + 35'(w_abs);
                    end
                    if (r_j == 3'(Order) && !r_rdv) begin
                        if (r_off >= 35'(r_diag)) r_ok <= 1'b0;
                        r_off <= '0;
                        r_j   <= '0;
                        if (w_last) begin
                            r_i     <= '0;
                            r_state <= S_CHECK;
                            r_cnt   <= 16'hFFFF;
                        end else begin
                            r_i <= r_i + IdxW'(1);
                        end
                    end
                end
                S_ROW: begin
                    if (r_j < 3'(Cols)) begin
                        r_jd    <= r_j;
                        r_rdv   <= 1'b1;
                        r_j     <= r_j + 3'd1;
                    end
                    if (r_rdv && r_jd == 3'(r_i)) r_den <= r_rd;
                    if (r_rdv || r_pv) begin
                        r_num <= r_num
                            + ((r_rdv && r_jd == 3'(Order)) ? 96'(r_rd) : 96'sd0)
                            - ((r_pv && r_pj != 3'(r_i)) ? 96'(w_tr) : 96'sd0);
                    end
                    if (r_j == 3'(Cols) && !r_rdv && !r_pv) r_j <= 3'(Cols + 1);
                    if (r_j == 3'(Cols + 1)) r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        r_x[r_i] <= w_rsp.quo;
                        r_j      <= '0;
                        r_num    <= '0;
                        if (w_last) begin
                            r_i     <= '0;
                            r_ok    <= 1'b1;
                            r_state <= S_CHECK;
                        end else begin
                            r_i     <= r_i + IdxW'(1);
                            r_state <= S_ROW;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_cnt == 16'hFFFF) begin
                        r_cnt <= '0;
                        if (!r_ok) begin
                            o_status <= StNotDom;
                            r_state  <= S_DONE;
                        end else begin
                            r_ok  <= 1'b0;
                            r_num <= '0;
                            r_state <= S_ROW;
                        end
                    end else begin
                        if (w_adx > 33'(r_tol)) r_ok <= 1'b0;
                        if (w_last) begin
                            r_i <= '0;
                            r_state <= S_DONE;
                            r_cnt <= r_cnt + 16'd1;
                            if (w_adx <= 33'(r_tol) && r_ok) o_status <= StConverged;
                            else if ((r_cnt + 16'd1) >= ((r_max == 16'd0) ? 16'd1 : r_max))
                                o_status <= StLimit;
                            else begin
                                for (int k = 0; k < Order; k++) r_px[k] <= r_x[k];
                                r_num   <= '0;
                                r_j     <= '0;
                                r_state <= S_ROW;
                            end
                        end else begin
                            r_i <= r_i + IdxW'(1);
                        end
                    end
                end
                S_DONE: begin
                    o_valid    <= 1'b1;
                    o_x_first  <= (o_status == StNotDom) ? '0 : r_x[0];
                    o_x_second <= (o_status == StNotDom) ? '0 : r_x[1];
                    o_x_third  <= (o_status == StNotDom) ? '0 : r_x[2];
                    o_sweeps   <= r_cnt;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double result strobe");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("busy during result");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("bad status");

endmodule
